@@ src/bsam_pkg.sv @@
package bsam_pkg;

  localparam logic [1:0] OP_MEM_RD = 2'd0;
  localparam logic [1:0] OP_MEM_WR = 2'd1;
  localparam logic [1:0] OP_IO_WR  = 2'd2;
  localparam logic [1:0] OP_IO_RD  = 2'd3;

  localparam logic [2:0] RGN_NONE   = 3'd0;
  localparam logic [2:0] RGN_IPL    = 3'd1;
  localparam logic [2:0] RGN_BASIC  = 3'd2;
  localparam logic [2:0] RGN_EXT    = 3'd3;
  localparam logic [2:0] RGN_RAM    = 3'd4;
  localparam logic [2:0] RGN_COMMON = 3'd5;

  localparam logic [7:0] PORT_ENABLE = 8'hfc;
  localparam logic [7:0] PORT_MODE   = 8'hfd;
  localparam logic [7:0] PORT_BANK   = 8'hfe;

  localparam logic [7:0] IO_ID_BYTE   = 8'he4;
  localparam logic [7:0] IO_IDLE_BYTE = 8'hff;
  localparam logic [7:0] ENABLE_RESET = 8'h80;

  localparam logic [15:0] COMMON_START = 16'hf800;
  localparam logic [17:0] BANK_BASE    = 18'h10000;
  localparam logic [17:0] IPL_BASE     = 18'h01000;
  localparam logic [17:0] RAM_C000     = 18'h0c000;
  localparam logic [17:0] RAM_E000     = 18'h0e000;

  typedef struct packed {
    logic [7:0] mode;
    logic [3:0] bank;
    logic [2:0] rom;
    logic       kanji;
  } map_state_t;

  typedef struct packed {
    logic [2:0]  region;
    logic [17:0] offset;
    logic        writable;
  } map_result_t;

endpackage

@@ src/bsam_if.sv @@
interface bsam_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] addr;
  logic [7:0]  data;

  modport source (output valid, output op, output addr, output data, input ready);
  modport sink   (input valid, input op, input addr, input data, output ready);
endinterface

interface bsam_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  region;
  logic [17:0] phys_offset;
  logic        write_enable;
  logic [7:0]  io_read_data;
  logic        sub_busreq;
  logic        sub_reset;

  modport source (output valid, output region, output phys_offset, output write_enable,
                  output io_read_data, output sub_busreq, output sub_reset, input ready);
  modport sink   (input valid, input region, input phys_offset, input write_enable,
                  input io_read_data, input sub_busreq, input sub_reset, output ready);
endinterface

interface bsam_cfg_if;
  logic valid;
  logic ready;
  logic kanji_rom_present;

  modport source (output valid, output kanji_rom_present, input ready);
  modport sink   (input valid, input kanji_rom_present, output ready);
endinterface

@@ src/bank_switch_address_mapper.sv @@
// Bus access translator: one request per cycle in, one result per request out, passing an
// input register, then decode of the small mode/bank/ROM registers into a result register.
// Memory requests return region, offset and write enable; I/O writes to ports
// 0xfc/0xfd/0xfe load the control registers and take effect for the next request, and every
// result carries the sub-CPU bus request level after its request. Stalls on the result side
// back up through both registers; configuration writes are taken in any cycle.
module bank_switch_address_mapper (
  input  logic              clk,
  input  logic              rst_n,
  bsam_in_if.sink           in_ch,
  bsam_out_if.source        out_ch,
  bsam_cfg_if.sink          cfg_ch
);

  logic        s1_v_r;
  logic [1:0]  s1_op_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic        out_v_r;
  logic        adv;
  logic        fire;

  bsam_pkg::map_state_t  st;
  bsam_pkg::map_result_t mres;
  logic [7:0] io_rd;
  logic       busreq;
  logic       srst;
  logic       is_mem;
  logic       is_wr;

  assign adv          = ~out_v_r | out_ch.ready;
  assign fire         = s1_v_r & adv;
  assign in_ch.ready  = ~s1_v_r | adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r   <= in_ch.op;
      s1_addr_r <= in_ch.addr;
      s1_data_r <= in_ch.data;
    end
  end

  bsam_map u_map (
    .addr (s1_addr_r),
    .st   (st),
    .res  (mres)
  );

  bsam_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .op           (s1_op_r),
    .port         (s1_addr_r[7:0]),
    .data         (s1_data_r),
    .cfg_we       (cfg_ch.valid),
    .cfg_kanji    (cfg_ch.kanji_rom_present),
    .st           (st),
    .io_read_data (io_rd),
    .sub_busreq   (busreq),
    .sub_reset    (srst)
  );

  assign is_mem = (s1_op_r == bsam_pkg::OP_MEM_RD) || (s1_op_r == bsam_pkg::OP_MEM_WR);
  assign is_wr  = (s1_op_r == bsam_pkg::OP_MEM_WR);

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.region       <= is_mem ? mres.region : bsam_pkg::RGN_NONE;
      out_ch.phys_offset  <= is_mem ? mres.offset : '0;
      out_ch.write_enable <= is_wr & mres.writable & (mres.region != bsam_pkg::RGN_NONE);
      out_ch.io_read_data <= io_rd;
      out_ch.sub_busreq   <= busreq;
      out_ch.sub_reset    <= srst;
    end
  end

  assign out_ch.valid = out_v_r;

endmodule

@@ src/bsam_map.sv @@
module bsam_map (
  input  logic                 [15:0] addr,
  input  bsam_pkg::map_state_t        st,
  output bsam_pkg::map_result_t       res
);

  logic [1:0]  m;
  logic [12:0] d_rom;
  logic [13:0] d_bank;
  logic [3:0]  ma_m2;
  logic [2:0]  mo_m3;
  logic [2:0]  mo_p1;
  logic [17:0] a18;
  logic [17:0] common_off;
  bsam_pkg::map_result_t r;

  assign m          = st.mode[1:0];
  assign a18        = {2'b00, addr};
  assign d_rom      = addr[12:0];
  assign d_bank     = addr[13:0];
  assign ma_m2      = st.bank - 4'd2;
  assign mo_m3      = st.rom - 3'd3;
  assign mo_p1      = st.rom + 3'd1;
  assign common_off = {7'd0, addr[10:0]};

  always_comb begin
    r = '{region: bsam_pkg::RGN_NONE, offset: '0, writable: 1'b0};
    if (m == 2'd1) begin
      if (addr < bsam_pkg::COMMON_START) begin
        r = '{region: bsam_pkg::RGN_RAM, offset: a18, writable: 1'b1};
      end else begin
        r = '{region: bsam_pkg::RGN_COMMON, offset: common_off, writable: 1'b1};
      end
    end else if (addr[15:13] == 3'd0) begin
      if (m == 2'd0) begin
        r = '{region: bsam_pkg::RGN_IPL,
              offset: bsam_pkg::IPL_BASE + {6'd0, addr[11:0]}, writable: 1'b0};
      end else if (m == 2'd2) begin
        r = '{region: bsam_pkg::RGN_BASIC, offset: a18, writable: 1'b0};
      end else begin
        r = '{region: bsam_pkg::RGN_RAM, offset: a18, writable: 1'b1};
      end
    end else if (addr[15:13] == 3'd1) begin
      if (m == 2'd0) begin
        r = '{region: bsam_pkg::RGN_BASIC, offset: a18, writable: 1'b0};
      end else if (st.rom >= 3'd3 && st.rom <= 3'd6) begin
        r = '{region: bsam_pkg::RGN_EXT, offset: {3'd0, mo_m3[1:0], d_rom}, writable: 1'b0};
      end else if (st.rom == 3'd7) begin
        r = '{region: bsam_pkg::RGN_NONE, offset: '0, writable: 1'b0};
      end else if (m == 2'd2) begin
        r = '{region: bsam_pkg::RGN_BASIC, offset: {2'd0, mo_p1, d_rom}, writable: 1'b0};
      end else if (st.rom == 3'd0) begin
        r = '{region: bsam_pkg::RGN_RAM, offset: a18, writable: 1'b1};
      end else if (st.rom == 3'd1) begin
        r = '{region: bsam_pkg::RGN_RAM,
              offset: bsam_pkg::RAM_C000 + {5'd0, d_rom}, writable: 1'b1};
      end else begin
        r = '{region: bsam_pkg::RGN_RAM,
              offset: bsam_pkg::RAM_E000 + {5'd0, d_rom}, writable: 1'b1};
      end
    end else if (addr[15:14] != 2'b11) begin
      r = '{region: bsam_pkg::RGN_RAM, offset: a18, writable: 1'b1};
    end else begin
      if (st.bank == 4'd15) begin
        if (addr >= bsam_pkg::COMMON_START) begin
          r = '{region: bsam_pkg::RGN_COMMON, offset: common_off, writable: 1'b1};
        end
      end else if (m == 2'd0 || m == 2'd2) begin
        if (st.bank == 4'd0) begin
          r = '{region: bsam_pkg::RGN_RAM, offset: a18, writable: 1'b1};
        end else if (st.bank == 4'd1) begin
          r = '{region: bsam_pkg::RGN_RAM, offset: {4'd0, d_bank}, writable: 1'b1};
        end else if (m == 2'd2 && st.bank <= 4'd13) begin
          r = '{region: bsam_pkg::RGN_RAM,
                offset: bsam_pkg::BANK_BASE + {ma_m2, d_bank}, writable: 1'b1};
        end
      end else begin
        if (st.bank <= 4'd11) begin
          r = '{region: bsam_pkg::RGN_RAM,
                offset: bsam_pkg::BANK_BASE + {st.bank, d_bank}, writable: 1'b1};
        end
      end
    end
    if (r.region == bsam_pkg::RGN_RAM && r.offset[17] && st.kanji) begin
      r.writable = 1'b0;
    end
  end

  assign res = r;

endmodule

@@ src/bsam_regs.sv @@
module bsam_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic                 [1:0] op,
  input  logic                 [7:0] port,
  input  logic                 [7:0] data,
  input  logic                       cfg_we,
  input  logic                       cfg_kanji,
  output bsam_pkg::map_state_t       st,
  output logic                 [7:0] io_read_data,
  output logic                       sub_busreq,
  output logic                       sub_reset
);

  logic [7:0] mode_r, mode_nxt;
  logic [3:0] bank_r, bank_nxt;
  logic [2:0] rom_r, rom_nxt;
  logic [7:0] enable_r, enable_nxt;
  logic       kanji_r;

  always_comb begin
    mode_nxt     = mode_r;
    bank_nxt     = bank_r;
    rom_nxt      = rom_r;
    enable_nxt   = enable_r;
    io_read_data = bsam_pkg::IO_IDLE_BYTE;
    sub_reset    = 1'b0;
    if (op == bsam_pkg::OP_IO_WR) begin
      unique case (port)
        bsam_pkg::PORT_ENABLE: enable_nxt = data;
        bsam_pkg::PORT_MODE: begin
          mode_nxt  = data;
          sub_reset = ~data[7];
        end
        bsam_pkg::PORT_BANK: begin
          rom_nxt  = data[2:0];
          bank_nxt = data[7:4];
        end
        default: ;
      endcase
    end else if (op == bsam_pkg::OP_IO_RD) begin
      unique case (port)
        bsam_pkg::PORT_MODE: io_read_data = mode_r;
        bsam_pkg::PORT_BANK: io_read_data = bsam_pkg::IO_ID_BYTE;
        default: ;
      endcase
    end
    sub_busreq = ~(~enable_nxt[1] & mode_nxt[7]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      bank_r   <= '0;
      rom_r    <= '0;
      enable_r <= bsam_pkg::ENABLE_RESET;
      kanji_r  <= 1'b0;
    end else begin
      if (fire) begin
        mode_r   <= mode_nxt;
        bank_r   <= bank_nxt;
        rom_r    <= rom_nxt;
        enable_r <= enable_nxt;
      end
      if (cfg_we) begin
        kanji_r <= cfg_kanji;
      end
    end
  end

  assign st = '{mode: mode_r, bank: bank_r, rom: rom_r, kanji: kanji_r};

endmodule

@@ dv/tb_bank_switch_address_mapper.sv @@
`timescale 1ns / 1ps

module tb_bank_switch_address_mapper;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_REQUESTS = 500;

  typedef struct packed {
    logic [2:0]  region;
    logic [17:0] offset;
    logic        wr_en;
    logic [7:0]  io_data;
    logic        busreq;
    logic        sub_rst;
  } bus_result_t;

  class bus_map_model;
    logic [7:0]  mode_r;
    logic [7:0]  enable_r;
    logic [3:0]  bank_r;
    logic [2:0]  rom_r;
    logic        kanji;
    bus_result_t pending_results[$];
    int          mismatches;
    int          unexpected;
    int          checked;
    int          mem_reqs;
    int          io_reqs;

    function new();
      mode_r = '0;
      enable_r = bsam_pkg::ENABLE_RESET;
      bank_r = '0;
      rom_r = '0;
      kanji = 1'b0;
      mismatches = 0;
      unexpected = 0;
      checked = 0;
      mem_reqs = 0;
      io_reqs = 0;
    endfunction

    function bsam_pkg::map_result_t place(logic [2:0] rgn, logic [17:0] off, logic wr);
      bsam_pkg::map_result_t res;
      res.region = rgn;
      res.offset = off;
      res.writable = wr;
      return res;
    endfunction

    function bsam_pkg::map_result_t map_address(logic [15:0] a);
      bsam_pkg::map_result_t res;
      logic [1:0]  m;
      logic [17:0] a18;
      logic [17:0] d;
      m = mode_r[1:0];
      a18 = {2'b00, a};
      res = place(bsam_pkg::RGN_NONE, '0, 1'b0);
      if (m == 2'd1) begin
        if (a < bsam_pkg::COMMON_START) res = place(bsam_pkg::RGN_RAM, a18, 1'b1);
        else res = place(bsam_pkg::RGN_COMMON, a18 - bsam_pkg::COMMON_START, 1'b1);
      end else if (a < 16'h2000) begin
        if (m == 2'd0)
          res = place(bsam_pkg::RGN_IPL, bsam_pkg::IPL_BASE + {6'd0, a[11:0]}, 1'b0);
        else if (m == 2'd2) res = place(bsam_pkg::RGN_BASIC, a18, 1'b0);
        else res = place(bsam_pkg::RGN_RAM, a18, 1'b1);
      end else if (a < 16'h4000) begin
        d = a18 - 18'h2000;
        if (m == 2'd0) res = place(bsam_pkg::RGN_BASIC, a18, 1'b0);
        else if (rom_r >= 3'd3 && rom_r <= 3'd6)
          res = place(bsam_pkg::RGN_EXT, ((18'(rom_r) - 18'd3) << 13) + d, 1'b0);
        else if (rom_r == 3'd7) res = place(bsam_pkg::RGN_NONE, '0, 1'b0);
        else if (m == 2'd2)
          res = place(bsam_pkg::RGN_BASIC, ((18'(rom_r) + 18'd1) << 13) + d, 1'b0);
        else if (rom_r == 3'd0) res = place(bsam_pkg::RGN_RAM, a18, 1'b1);
        else if (rom_r == 3'd1) res = place(bsam_pkg::RGN_RAM, bsam_pkg::RAM_C000 + d, 1'b1);
        else res = place(bsam_pkg::RGN_RAM, bsam_pkg::RAM_E000 + d, 1'b1);
      end else if (a < 16'hc000) begin
        res = place(bsam_pkg::RGN_RAM, a18, 1'b1);
      end else begin
        d = a18 - 18'hc000;
        if (bank_r == 4'd15) begin
          if (a >= bsam_pkg::COMMON_START)
            res = place(bsam_pkg::RGN_COMMON, a18 - bsam_pkg::COMMON_START, 1'b1);
        end else if (m == 2'd0) begin
          if (bank_r == 4'd0) res = place(bsam_pkg::RGN_RAM, a18, 1'b1);
          else if (bank_r == 4'd1) res = place(bsam_pkg::RGN_RAM, d, 1'b1);
        end else if (m == 2'd2) begin
          if (bank_r == 4'd0) res = place(bsam_pkg::RGN_RAM, a18, 1'b1);
          else if (bank_r == 4'd1) res = place(bsam_pkg::RGN_RAM, d, 1'b1);
          else if (bank_r <= 4'd13)
            res = place(bsam_pkg::RGN_RAM,
                        bsam_pkg::BANK_BASE + ((18'(bank_r) - 18'd2) << 14) + d, 1'b1);
        end else if (bank_r <= 4'd11) begin
          res = place(bsam_pkg::RGN_RAM, bsam_pkg::BANK_BASE + (18'(bank_r) << 14) + d, 1'b1);
        end
      end
      if (res.region == bsam_pkg::RGN_RAM && res.offset >= 18'h20000 && kanji)
        res.writable = 1'b0;
      return res;
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
      bus_result_t r;
      bsam_pkg::map_result_t mr;
      r.region = bsam_pkg::RGN_NONE;
      r.offset = '0;
      r.wr_en = 1'b0;
      r.io_data = bsam_pkg::IO_IDLE_BYTE;
      r.sub_rst = 1'b0;
      case (op)
        bsam_pkg::OP_MEM_RD, bsam_pkg::OP_MEM_WR: begin
          mem_reqs++;
          mr = map_address(addr);
          r.region = mr.region;
          r.offset = mr.offset;
          r.wr_en = (op == bsam_pkg::OP_MEM_WR) && mr.writable &&
                    (mr.region != bsam_pkg::RGN_NONE);
        end
        bsam_pkg::OP_IO_WR: begin
          io_reqs++;
          case (addr[7:0])
            bsam_pkg::PORT_ENABLE: enable_r = data;
            bsam_pkg::PORT_MODE: begin
              mode_r = data;
              r.sub_rst = !data[7];
            end
            bsam_pkg::PORT_BANK: begin
              rom_r = data[2:0];
              bank_r = data[7:4];
            end
            default: ;
          endcase
        end
        bsam_pkg::OP_IO_RD: begin
          io_reqs++;
          if (addr[7:0] == bsam_pkg::PORT_MODE) r.io_data = mode_r;
          else if (addr[7:0] == bsam_pkg::PORT_BANK) r.io_data = bsam_pkg::IO_ID_BYTE;
        end
      endcase
      r.busreq = !(!enable_r[1] && mode_r[7]);
      pending_results.push_back(r);
    endfunction

    function void check_result(bus_result_t got);
      bus_result_t want;
      if (pending_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result: region %0d offset %h", got.region, got.offset);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches + unexpected <= 10) begin
          $display("result %0d mismatch (exp/got): region %0d/%0d offset %h/%h we %b/%b",
                   checked, want.region, got.region, want.offset, got.offset,
                   want.wr_en, got.wr_en);
          $display("  io %h/%h busreq %b/%b sub_reset %b/%b",
                   want.io_data, got.io_data, want.busreq, got.busreq,
                   want.sub_rst, got.sub_rst);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   burst_left;
  int   stall_mode;
  int   stall_timer;
  int   kanji_writes;

  logic [15:0] boundary_addrs [10] = '{16'h0000, 16'h1fff, 16'h2000, 16'h3fff, 16'h4000,
                                       16'hbfff, 16'hc000, 16'hf7ff, 16'hf800, 16'hffff};

  bus_map_model mapper_model;

  bsam_in_if  in_ch();
  bsam_out_if out_ch();
  bsam_cfg_if cfg_ch();

  bank_switch_address_mapper u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bank_switch_address_mapper: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      mapper_model.note_request(in_ch.op, in_ch.addr, in_ch.data);
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      mapper_model.check_result({out_ch.region, out_ch.phys_offset, out_ch.write_enable,
                                 out_ch.io_read_data, out_ch.sub_busreq, out_ch.sub_reset});
  end

  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_timer = $urandom_range(20, 120);
    end
    stall_timer--;
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ((cycles % 5) < 2);
    endcase
  end

  task automatic send_request(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.addr <= addr;
    in_ch.data <= data;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (mapper_model.pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_kanji(logic value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.kanji_rom_present <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    mapper_model.kanji = value;
    kanji_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random();
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    int          pick;
    pick = $urandom_range(0, 99);
    addr = 16'($urandom);
    data = 8'($urandom);
    if (pick < 50) begin
      op = $urandom_range(0, 1) ? bsam_pkg::OP_MEM_WR : bsam_pkg::OP_MEM_RD;
      if ($urandom_range(0, 4) == 0) addr = boundary_addrs[$urandom_range(0, 9)];
    end else if (pick < 80) begin
      op = bsam_pkg::OP_IO_WR;
      case ($urandom_range(0, 9))
        0, 1, 2: addr[7:0] = bsam_pkg::PORT_ENABLE;
        3, 4, 5: addr[7:0] = bsam_pkg::PORT_MODE;
        6, 7, 8: addr[7:0] = bsam_pkg::PORT_BANK;
        default: ;
      endcase
    end else begin
      op = bsam_pkg::OP_IO_RD;
      case ($urandom_range(0, 2))
        0: addr[7:0] = bsam_pkg::PORT_MODE;
        1: addr[7:0] = bsam_pkg::PORT_BANK;
        default: ;
      endcase
    end
    send_request(op, addr, data);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_timer = 0;
    kanji_writes = 0;
    in_ch.valid = 1'b0;
    in_ch.op = bsam_pkg::OP_MEM_RD;
    in_ch.addr = '0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.kanji_rom_present = 1'b0;
    mapper_model = new();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_kanji(1'b0);

    send_request(bsam_pkg::OP_MEM_RD, 16'h0000, 8'h00);
    send_request(bsam_pkg::OP_MEM_WR, 16'hffff, 8'hff);
    send_request(bsam_pkg::OP_IO_RD, {8'h00, bsam_pkg::PORT_MODE}, 8'h00);
    send_request(bsam_pkg::OP_IO_RD, {8'hff, bsam_pkg::PORT_BANK}, 8'h00);
    send_request(bsam_pkg::OP_IO_RD, 16'h0000, 8'h00);
    send_request(bsam_pkg::OP_IO_WR, 16'h0012, 8'hff);
    send_request(bsam_pkg::OP_IO_WR, {8'h00, bsam_pkg::PORT_ENABLE}, 8'h00);
    send_request(bsam_pkg::OP_IO_WR, {8'h00, bsam_pkg::PORT_MODE}, 8'h83);
    send_request(bsam_pkg::OP_IO_RD, {8'h00, bsam_pkg::PORT_MODE}, 8'h00);
    send_request(bsam_pkg::OP_IO_WR, {8'h00, bsam_pkg::PORT_BANK}, 8'hb5);
    send_request(bsam_pkg::OP_MEM_WR, 16'hc000, 8'h5a);
    send_request(bsam_pkg::OP_MEM_WR, 16'h2000, 8'ha5);
    send_request(bsam_pkg::OP_IO_WR, {8'h00, bsam_pkg::PORT_BANK}, 8'hc7);
    send_request(bsam_pkg::OP_MEM_WR, 16'hd000, 8'h00);
    send_request(bsam_pkg::OP_MEM_RD, 16'h3fff, 8'h00);
    send_request(bsam_pkg::OP_IO_WR, {8'h00, bsam_pkg::PORT_BANK}, 8'hf0);
    send_request(bsam_pkg::OP_MEM_WR, 16'hf800, 8'h00);
    send_request(bsam_pkg::OP_MEM_RD, 16'hf7ff, 8'h00);
    send_request(bsam_pkg::OP_IO_WR, {8'h00, bsam_pkg::PORT_MODE}, 8'h01);
    send_request(bsam_pkg::OP_MEM_WR, 16'hffff, 8'h00);
    send_request(bsam_pkg::OP_IO_WR, {8'h00, bsam_pkg::PORT_MODE}, 8'h7e);
    send_request(bsam_pkg::OP_MEM_WR, 16'h1fff, 8'h00);
    drain_requests();

    write_kanji(1'b1);
    send_request(bsam_pkg::OP_IO_WR, {8'h00, bsam_pkg::PORT_BANK}, 8'hb0);
    send_request(bsam_pkg::OP_IO_WR, {8'h00, bsam_pkg::PORT_MODE}, 8'h03);
    send_request(bsam_pkg::OP_MEM_WR, 16'hc000, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      drain_requests();
      write_kanji(phase % 2 == 0);
      repeat (PHASE_REQUESTS) send_random();
    end
    drain_requests();

    $display("covered %0d memory and %0d io requests over %0d kanji ROM settings",
             mapper_model.mem_reqs, mapper_model.io_reqs, kanji_writes);
    $display("%0d results checked, %0d mismatched, %0d unexpected, %0d missing",
             mapper_model.checked, mapper_model.mismatches, mapper_model.unexpected,
             mapper_model.pending_results.size());
    if (mapper_model.mismatches == 0 && mapper_model.unexpected == 0 &&
        mapper_model.pending_results.size() == 0) begin
      $display("tb_bank_switch_address_mapper: PASS");
    end else begin
      $display("tb_bank_switch_address_mapper: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/bsam_pkg.sv
src/bsam_if.sv
src/bsam_map.sv
src/bsam_regs.sv
src/bank_switch_address_mapper.sv
dv/tb_bank_switch_address_mapper.sv
